// ----- design/mmc_pkg.sv -----
// Package for the magnetometer min/max calibration unit: payload types, widths,
// command codes and reset coefficients. Used by mmc_mul and the top level.
`default_nettype none

package mmc_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int SCALE_W             = 16;
    localparam int OUT_W               = 24;
    localparam int DEF_SCALE_FRAC_BITS = 14;
    localparam int MINMAX_W            = (SAMPLE_W > 16) ? SAMPLE_W : 16;
    localparam int BIAS_W              = SAMPLE_W + 1;
    localparam int RANGE_W             = SAMPLE_W;
    localparam int SUM_W               = SAMPLE_W + 2;
    localparam int DEN_W               = SAMPLE_W + 2;
    localparam int NUM_AXES            = 3;
    localparam int AXIS_W              = 2;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_END    = 2'd2;

    localparam logic signed [MINMAX_W-1:0] MIN_START = MINMAX_W'(30000);
    localparam logic signed [MINMAX_W-1:0] MAX_START = MINMAX_W'(-30000);
    localparam logic [SCALE_W-1:0]         SCALE_MAX = '1;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] corrected_x;
        logic signed [OUT_W-1:0] corrected_y;
        logic signed [OUT_W-1:0] corrected_z;
        logic                    calibration_done;
    } t_out_item;

    // Factory hard-iron offsets, Q.1.
    function automatic logic signed [BIAS_W-1:0] bias_reset(input logic [AXIS_W-1:0] axis);
        logic signed [BIAS_W-1:0] v;
        case (axis)
            2'd0:    v = BIAS_W'(68);
            2'd1:    v = BIAS_W'(8);
            2'd2:    v = BIAS_W'(75);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Factory soft-iron gains, Q2.14.
    function automatic logic [SCALE_W-1:0] scale_reset(input logic [AXIS_W-1:0] axis);
        logic [SCALE_W-1:0] v;
        case (axis)
            2'd0:    v = SCALE_W'(15276);
            2'd1:    v = SCALE_W'(19976);
            2'd2:    v = SCALE_W'(14797);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/mmc_div.sv -----
// Restoring serial divider, one quotient bit per cycle, shared by all axes.
// Depends on nothing but its parameters.
`default_nettype none

module mmc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   w_shift;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_num[NUM_W-1]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
        // For a nonzero divisor the new remainder is below the divisor, so it fits DEN_W bits.
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend register shifts out at the top and collects quotient bits at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

`default_nettype wire

// ----- design/mmc_mul.sv -----
// Shared correction datapath: (2*sample - bias) * scale, arithmetic shift and
// saturation to the output width, in three register stages. Uses mmc_pkg.
`default_nettype none

module mmc_mul #(
    parameter int SCALE_FRAC_BITS = mmc_pkg::DEF_SCALE_FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_go,
    input  wire logic signed [mmc_pkg::SAMPLE_W-1:0] i_smp,
    input  wire logic signed [mmc_pkg::BIAS_W-1:0]   i_bias,
    input  wire logic        [mmc_pkg::SCALE_W-1:0]  i_scale,
    output logic                                     o_done,
    output logic signed      [mmc_pkg::OUT_W-1:0]    o_val
);
    import mmc_pkg::*;

    localparam int D_W   = SAMPLE_W + 2;
    localparam int P_W   = D_W + SCALE_W + 1;
    localparam int SHIFT = SCALE_FRAC_BITS - 3;

    logic [2:0]               r_v;
    logic signed [D_W-1:0]    r_d;
    logic signed [SCALE_W:0]  r_scale;
    logic signed [P_W-1:0]    r_prod;
    logic signed [OUT_W-1:0]  r_val;

    logic signed [D_W-1:0]    w_twice;
    logic signed [D_W-1:0]    w_bias;
    logic signed [P_W-1:0]    w_prod;
    logic signed [P_W-1:0]    w_sh;
    logic signed [OUT_W-1:0]  w_sat;

    always_comb begin
        w_twice = {i_smp[SAMPLE_W-1], i_smp, 1'b0};
        w_bias  = {i_bias[BIAS_W-1], i_bias};
        w_prod  = r_d * r_scale;
        w_sh    = r_prod >>> SHIFT;
        if (!w_sh[P_W-1] && (|w_sh[P_W-2:OUT_W-1])) begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (w_sh[P_W-1] && !(&w_sh[P_W-2:OUT_W-1])) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = w_sh[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_go};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= w_twice - w_bias;
        r_scale <= {1'b0, i_scale};
        r_prod  <= w_prod;
        r_val   <= w_sat;
    end

    assign o_done = r_v[2];
    assign o_val  = r_val;

endmodule

`default_nettype wire

// ----- design/magnetometer_minmax_calibration_unit.sv -----
// Top level of the magnetometer min/max calibration unit: command decode,
// envelope and coefficient registers, sequencer. Uses mmc_pkg, mmc_div, mmc_mul.
//
//   Channel  Dir  Handshake          Payload
//   input    in   i_valid / o_ready  i_item (t_in_item)
//   output   out  o_valid / i_ready  o_item (t_out_item)
//
// Start, end, unused and all-zero items are taken while idle and give no result. A sample
// makes three passes through the shared multiply stage, one per axis, before its result is
// loaded into the output register. Ending calibration adds a bias step and three divisions,
// one per axis, in the serial divider at one quotient bit per cycle. Reset is synchronous
// and restores the factory bias and scale. o_ready stays low while a sample is in work,
// including while its result waits for a stalled consumer to free the output register.
`default_nettype none

module magnetometer_minmax_calibration_unit #(
    parameter int SCALE_FRAC_BITS = mmc_pkg::DEF_SCALE_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire mmc_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output mmc_pkg::t_out_item      o_item
);
    import mmc_pkg::*;

    localparam int NUM_W = SUM_W + SCALE_FRAC_BITS;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_BIAS     = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_MUL_GO   = 3'd4;
    localparam logic [2:0] S_MUL_WAIT = 3'd5;
    localparam logic [2:0] S_PUT      = 3'd6;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    logic [2:0]               r_state, n_state;
    logic [AXIS_W-1:0]        r_axis, n_axis;
    logic                     r_cal_active;
    logic                     r_end_pending;
    logic                     r_done_flag;
    logic signed [MINMAX_W-1:0] r_min   [NUM_AXES];
    logic signed [MINMAX_W-1:0] r_max   [NUM_AXES];
    logic signed [BIAS_W-1:0]   r_bias  [NUM_AXES];
    logic        [SCALE_W-1:0]  r_scale [NUM_AXES];
    logic signed [SAMPLE_W-1:0] r_smp   [NUM_AXES];
    logic signed [OUT_W-1:0]    r_corr  [NUM_AXES];
    logic [SUM_W-1:0]         r_sum;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic                     w_accept;
    logic                     w_nonzero;
    logic signed [SAMPLE_W-1:0] w_in_smp [NUM_AXES];
    logic [RANGE_W-1:0]       w_range  [NUM_AXES];
    logic signed [MINMAX_W:0] w_diff   [NUM_AXES];
    logic signed [MINMAX_W:0] w_bsum   [NUM_AXES];
    logic [RANGE_W-1:0]       w_rng_sel;
    logic [DEN_W-1:0]         w_den;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quo;
    logic [SCALE_W-1:0]       w_quo_sat;
    logic                     w_mul_go;
    logic                     w_mul_done;
    logic signed [OUT_W-1:0]  w_mul_val;
    logic                     w_out_free;

    assign w_in_smp[0] = i_item.sample_x;
    assign w_in_smp[1] = i_item.sample_y;
    assign w_in_smp[2] = i_item.sample_z;
    assign w_nonzero   = (i_item.sample_x != '0) || (i_item.sample_y != '0)
                      || (i_item.sample_z != '0);

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Once a sample has updated the envelope, max and min are both sample values,
    // so the range and the offset fit their narrow widths.
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_diff[i]  = {r_max[i][MINMAX_W-1], r_max[i]} - {r_min[i][MINMAX_W-1], r_min[i]};
            w_bsum[i]  = {r_max[i][MINMAX_W-1], r_max[i]} + {r_min[i][MINMAX_W-1], r_min[i]};
            w_range[i] = w_diff[i][RANGE_W-1:0];
        end
        w_rng_sel = w_range[r_axis];
        w_den     = {2'b00, w_rng_sel} + {1'b0, w_rng_sel, 1'b0};
        w_quo_sat = (|w_quo[NUM_W-1:SCALE_W]) ? SCALE_MAX : w_quo[SCALE_W-1:0];
    end

    assign w_div_start = (r_state == S_DIV_GO);
    assign w_mul_go    = (r_state == S_MUL_GO);
    assign w_out_free  = !r_out_valid || i_ready;

    mmc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_sum, {SCALE_FRAC_BITS{1'b0}}}),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    mmc_mul #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_mul_go),
        .i_smp   (r_smp[r_axis]),
        .i_bias  (r_bias[r_axis]),
        .i_scale (r_scale[r_axis]),
        .o_done  (w_mul_done),
        .o_val   (w_mul_val)
    );

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                n_axis = '0;
                if (w_accept && (i_item.mode == MODE_SAMPLE) && w_nonzero) begin
                    n_state = (r_cal_active && r_end_pending) ? S_BIAS : S_MUL_GO;
                end
            end
            S_BIAS: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    if (r_axis == LAST_AXIS) begin
                        n_axis  = '0;
                        n_state = S_MUL_GO;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_MUL_GO: begin
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (w_mul_done) begin
                    if (r_axis == LAST_AXIS) begin
                        n_state = S_PUT;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_PUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_axis        <= '0;
            r_cal_active  <= 1'b0;
            r_end_pending <= 1'b0;
            r_done_flag   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_sum         <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_min[i]   <= '0;
                r_max[i]   <= '0;
                r_bias[i]  <= bias_reset(AXIS_W'(i));
                r_scale[i] <= scale_reset(AXIS_W'(i));
            end
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;

            if (w_accept) begin
                case (i_item.mode)
                    MODE_START: begin
                        r_cal_active <= 1'b1;
                        for (int i = 0; i < NUM_AXES; i++) begin
                            r_min[i] <= MIN_START;
                            r_max[i] <= MAX_START;
                        end
                    end
                    MODE_END: begin
                        r_end_pending <= 1'b1;
                    end
                    MODE_SAMPLE: begin
                        if (w_nonzero) begin
                            r_done_flag <= r_cal_active && r_end_pending;
                            if (r_cal_active) begin
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    if (MINMAX_W'(w_in_smp[i]) > r_max[i]) begin
                                        r_max[i] <= MINMAX_W'(w_in_smp[i]);
                                    end
                                    if (MINMAX_W'(w_in_smp[i]) < r_min[i]) begin
                                        r_min[i] <= MINMAX_W'(w_in_smp[i]);
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_BIAS) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_bias[i] <= w_bsum[i][BIAS_W-1:0];
                end
                r_sum         <= SUM_W'(w_range[0]) + SUM_W'(w_range[1]) + SUM_W'(w_range[2]);
                r_cal_active  <= 1'b0;
                r_end_pending <= 1'b0;
            end

            // A zero range divides by zero; the gain then saturates as well.
            if ((r_state == S_DIV_WAIT) && w_div_done) begin
                r_scale[r_axis] <= (w_rng_sel == '0) ? SCALE_MAX : w_quo_sat;
            end

            if ((r_state == S_PUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_smp[i] <= w_in_smp[i];
            end
        end
        if ((r_state == S_MUL_WAIT) && w_mul_done) begin
            r_corr[r_axis] <= w_mul_val;
        end
        if ((r_state == S_PUT) && w_out_free) begin
            r_out_item.corrected_x      <= r_corr[0];
            r_out_item.corrected_y      <= r_corr[1];
            r_out_item.corrected_z      <= r_corr[2];
            r_out_item.calibration_done <= r_done_flag;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

`default_nettype wire
